### hdl/gou_pkg.sv
package gou_pkg;

    // field widths
    localparam int IDX_W = 16;
    localparam int VAL_W = 32;
    localparam int FAC_W = 32;
    localparam int MAG_W = 49;
    localparam int SD_W  = 48;
    localparam int ROOT_W = 24;

    // store depth
    localparam int GOU_PARAM_COUNT = 65536;

    // update rules
    localparam logic [1:0] MODE_MOMENTUM = 2'd1;
    localparam logic [1:0] MODE_RMSPROP  = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_RATE_INIT = 3'd1;
    localparam logic [2:0] CFG_RATE_DEC  = 3'd2;
    localparam logic [2:0] CFG_HIST      = 3'd3;
    localparam logic [2:0] CFG_DEC_EN    = 3'd4;

    // register reset values
    localparam logic [1:0]       RST_MODE      = 2'd0;
    localparam logic [FAC_W-1:0] RST_RATE_INIT = 32'd42949673;
    localparam logic [FAC_W-1:0] RST_RATE_DEC  = 32'hFFFF_FFFF;
    localparam logic [FAC_W-1:0] RST_HIST      = 32'd3865470566;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_RD,
        S_VLD,
        S_MOM_HV,
        S_RMS_G2,
        S_RMS_DV,
        S_RMS_KG,
        S_RMS_SQ,
        S_RMS_DIV,
        S_RATE,
        S_DECAY,
        S_OUT
    } gou_state_t;

    // request to the root/divide unit
    typedef struct packed {
        logic start;
        logic sqrt_op;
    } sd_req_t;

endpackage

### hdl/gou_ram.sv
module gou_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/gou_mul.sv
module gou_mul import gou_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [FAC_W-1:0] f,
    input  logic [MAG_W-1:0] mag,
    output logic             done,
    output logic [MAG_W-1:0] prod
);

    logic [FAC_W-1:0] f_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [MAG_W:0]   hi_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [MAG_W:0]   sum;

    // add multiplicand for one factor bit, drop the low bit
    assign sum = hi_reg + (f_reg[0] ? {1'b0, mag_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            f_reg   <= f;
            mag_reg <= mag;
            hi_reg  <= '0;
        end else if (busy_reg) begin
            f_reg  <= f_reg >> 1;
            hi_reg <= sum >> 1;
        end
    end

    assign done = done_reg;
    assign prod = hi_reg[MAG_W-1:0];

endmodule

### hdl/gou_sqdiv.sv
module gou_sqdiv import gou_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  sd_req_t           req,
    input  logic [SD_W-1:0]   src,
    input  logic [ROOT_W-1:0] dvs,
    output logic              done,
    output logic [SD_W-1:0]   res
);

    logic [SD_W-1:0]   src_reg;
    logic [ROOT_W-1:0] dvs_reg;
    logic [SD_W-1:0]   res_reg;
    logic [24:0]       rem_reg;
    logic [5:0]        cnt_reg;
    logic              sqrt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [26:0]       rem_t;
    logic [26:0]       cmp;
    logic [26:0]       diff;
    logic              ge;

    // one root or quotient bit per cycle, restoring
    always_comb begin
        if (sqrt_reg) begin
            rem_t = {rem_reg, src_reg[SD_W-1 -: 2]};
            cmp   = {1'b0, res_reg[ROOT_W-1:0], 2'b01};
        end else begin
            rem_t = {1'b0, rem_reg, src_reg[SD_W-1]};
            cmp   = {3'b000, dvs_reg};
        end
        ge   = (rem_t >= cmp);
        diff = rem_t - cmp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 6'd0);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.sqrt_op ? 6'(ROOT_W - 1) : 6'(SD_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            src_reg  <= src;
            dvs_reg  <= dvs;
            sqrt_reg <= req.sqrt_op;
            res_reg  <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            src_reg <= sqrt_reg ? (src_reg << 2) : (src_reg << 1);
            res_reg <= {res_reg[SD_W-2:0], ge};
            rem_reg <= ge ? diff[24:0] : rem_t[24:0];
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### hdl/gradient_optimizer_update.sv
// channel   direction  ports
// s_        in         s_valid s_ready s_index s_value_in s_gradient s_step_end
// m_        out        m_valid m_ready m_index_out m_value_out
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data
// a transaction uses the bit-serial multiplier; momentum and rmsprop first reduce
// the index modulo the store depth, and rmsprop also uses the root/divide unit,
// one root or quotient bit per cycle; a step end with the rate decay enabled
// adds one more multiply that decays the rate.
// after reset a clearing pass zeroes every entry of the velocity store;
// no input transaction is taken during it, config writes are always taken.
// a finished result waits in the output register while the next item is accepted.
module gradient_optimizer_update import gou_pkg::*; #(
    parameter int PARAM_COUNT = GOU_PARAM_COUNT,
    localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [IDX_W-1:0]        s_index,
    input  logic signed [VAL_W-1:0] s_value_in,
    input  logic signed [VAL_W-1:0] s_gradient,
    input  logic                    s_step_end,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_index_out,
    output logic signed [VAL_W-1:0] m_value_out,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [FAC_W-1:0]        cfg_data
);

    localparam logic [AW:0]   P_VAL  = (AW + 1)'(PARAM_COUNT);
    localparam logic [AW-1:0] P_LAST = AW'(PARAM_COUNT - 1);

    gou_state_t state_reg, state_next;

    logic [1:0]       mode_reg;
    logic [FAC_W-1:0] rdec_reg, hist_reg, wr_reg, wr_next;
    logic             dec_en_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [VAL_W-1:0] pval_reg, grad_reg;
    logic             last_reg;
    logic [3:0]       cnt_reg, cnt_next;
    logic [AW-1:0]    rem_reg, rem_next, clr_reg;
    logic [VAL_W-1:0] vel_reg, vel_next, gsq_reg, gsq_next, t1_reg, t1_next;
    logic             neg_reg, neg_next;
    logic [VAL_W-1:0] res_reg, res_next;
    logic             m_valid_reg;
    logic [IDX_W-1:0] m_index_reg;
    logic [VAL_W-1:0] m_value_reg;

    logic             mul_start, mul_done;
    logic [FAC_W-1:0] mul_f;
    logic [MAG_W-1:0] mul_mag, mul_prod;
    sd_req_t          sd_req;
    logic [SD_W-1:0]  sd_src, sd_res;
    logic [ROOT_W-1:0] sd_dvs, root;
    logic             sd_done;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;

    logic             s_acc, out_load;
    logic [VAL_W-1:0] gm, vm, vnew, s_gm;
    logic [AW:0]      red_t;
    logic [33:0]      vsum;
    logic [32:0]      rsum, keep;
    logic [50:0]      dsum;

    gou_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .f       (mul_f),
        .mag     (mul_mag),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    gou_sqdiv u_sqdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sd_req),
        .src     (sd_src),
        .dvs     (sd_dvs),
        .done    (sd_done),
        .res     (sd_res)
    );

    gou_ram #(
        .WIDTH (VAL_W),
        .DEPTH (PARAM_COUNT)
    ) u_vel_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rem_reg),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // magnitudes of gradient and stored velocity
    assign gm   = grad_reg[VAL_W-1] ? (~grad_reg + 32'd1) : grad_reg;
    assign s_gm = s_gradient[VAL_W-1] ? (~s_gradient + 32'd1) : s_gradient;
    assign vm   = ram_rdata[VAL_W-1] ? (~ram_rdata + 32'd1) : ram_rdata;
    assign keep = 33'h1_0000_0000 - {1'b0, hist_reg};
    assign red_t = {rem_reg, idx_reg[cnt_reg]};
    assign root  = (sd_res[ROOT_W-1:0] == '0) ? ROOT_W'(1) : sd_res[ROOT_W-1:0];

    // momentum or rmsprop velocity with saturation
    always_comb begin
        vsum = (vel_reg[VAL_W-1] ? -{3'b000, mul_prod[30:0]} : {3'b000, mul_prod[30:0]})
             + {{2{grad_reg[VAL_W-1]}}, grad_reg};
        rsum = {1'b0, t1_reg} + mul_prod[32:0];
        if (mode_reg == MODE_MOMENTUM) begin
            if (vsum[33:31] == 3'b000 || vsum[33:31] == 3'b111) begin
                vnew = vsum[31:0];
            end else begin
                vnew = vsum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end else begin
            vnew = rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
        end
    end

    // final value with saturation
    always_comb begin
        dsum = neg_reg ? ({{19{pval_reg[VAL_W-1]}}, pval_reg} + {2'b00, mul_prod})
                       : ({{19{pval_reg[VAL_W-1]}}, pval_reg} - {2'b00, mul_prod});
        if (dsum[50:31] == '0 || dsum[50:31] == '1) begin
            res_next = dsum[31:0];
        end else begin
            res_next = dsum[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        vel_next   = vel_reg;
        gsq_next   = gsq_reg;
        t1_next    = t1_reg;
        neg_next   = neg_reg;
        wr_next    = wr_reg;
        mul_start  = 1'b0;
        mul_f      = '0;
        mul_mag    = '0;
        sd_req     = '0;
        sd_src     = '0;
        sd_dvs     = '0;
        ram_we     = 1'b0;
        ram_waddr  = rem_reg;
        ram_wdata  = vnew;
        out_load   = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == P_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    if (mode_reg == MODE_MOMENTUM || mode_reg == MODE_RMSPROP) begin
                        cnt_next   = 4'd15;
                        rem_next   = '0;
                        state_next = S_SLOT;
                    end else begin
                        mul_start  = 1'b1;
                        mul_f      = wr_reg;
                        mul_mag    = {17'd0, s_gm};
                        neg_next   = s_gradient[VAL_W-1];
                        state_next = S_RATE;
                    end
                end
            end
            // index modulo store depth, one index bit per cycle
            S_SLOT: begin
                rem_next = (red_t >= P_VAL) ? AW'(red_t - P_VAL) : red_t[AW-1:0];
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_VLD;
            end
            S_VLD: begin
                vel_next  = ram_rdata;
                mul_start = 1'b1;
                if (mode_reg == MODE_MOMENTUM) begin
                    mul_f      = hist_reg;
                    mul_mag    = {17'd0, vm};
                    state_next = S_MOM_HV;
                end else begin
                    mul_f      = gm;
                    mul_mag    = {1'b0, gm, 16'd0};
                    state_next = S_RMS_G2;
                end
            end
            S_MOM_HV: begin
                if (mul_done) begin
                    ram_we     = 1'b1;
                    mul_start  = 1'b1;
                    mul_f      = wr_reg;
                    mul_mag    = {17'd0, (vnew[VAL_W-1] ? (~vnew + 32'd1) : vnew)};
                    neg_next   = vnew[VAL_W-1];
                    state_next = S_RATE;
                end
            end
            S_RMS_G2: begin
                if (mul_done) begin
                    gsq_next   = (mul_prod[MAG_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                              : mul_prod[31:0];
                    mul_start  = 1'b1;
                    mul_f      = hist_reg;
                    mul_mag    = {17'd0, vel_reg};
                    state_next = S_RMS_DV;
                end
            end
            S_RMS_DV: begin
                if (mul_done) begin
                    t1_next    = mul_prod[31:0];
                    mul_start  = 1'b1;
                    mul_f      = gsq_reg;
                    mul_mag    = {16'd0, keep};
                    state_next = S_RMS_KG;
                end
            end
            S_RMS_KG: begin
                if (mul_done) begin
                    ram_we         = 1'b1;
                    sd_req.start   = 1'b1;
                    sd_req.sqrt_op = 1'b1;
                    sd_src         = {vnew, 16'd0};
                    state_next     = S_RMS_SQ;
                end
            end
            S_RMS_SQ: begin
                if (sd_done) begin
                    sd_req.start = 1'b1;
                    sd_src       = {gm, 16'd0};
                    sd_dvs       = root;
                    state_next   = S_RMS_DIV;
                end
            end
            S_RMS_DIV: begin
                if (sd_done) begin
                    mul_start  = 1'b1;
                    mul_f      = wr_reg;
                    mul_mag    = {1'b0, sd_res};
                    neg_next   = grad_reg[VAL_W-1];
                    state_next = S_RATE;
                end
            end
            S_RATE: begin
                if (mul_done) begin
                    if (last_reg && dec_en_reg) begin
                        mul_start  = 1'b1;
                        mul_f      = rdec_reg;
                        mul_mag    = {17'd0, wr_reg};
                        state_next = S_DECAY;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DECAY: begin
                if (mul_done) begin
                    wr_next    = mul_prod[31:0];
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // rate register load from config
        if (cfg_valid && cfg_index == CFG_RATE_INIT) begin
            wr_next = cfg_data;
        end
    end

    // control and config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            mode_reg    <= RST_MODE;
            rdec_reg    <= RST_RATE_DEC;
            hist_reg    <= RST_HIST;
            dec_en_reg  <= 1'b0;
            wr_reg      <= RST_RATE_INIT;
        end else begin
            state_reg <= state_next;
            wr_reg    <= wr_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MODE:      mode_reg   <= cfg_data[1:0];
                    CFG_RATE_DEC:  rdec_reg   <= cfg_data;
                    CFG_HIST:      hist_reg   <= cfg_data;
                    CFG_DEC_EN:    dec_en_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            idx_reg  <= s_index;
            pval_reg <= s_value_in;
            grad_reg <= s_gradient;
            last_reg <= s_step_end;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        vel_reg <= vel_next;
        gsq_reg <= gsq_next;
        t1_reg  <= t1_next;
        neg_reg <= neg_next;
        if (state_reg == S_RATE && mul_done) begin
            res_reg <= res_next;
        end
        if (out_load) begin
            m_index_reg <= idx_reg;
            m_value_reg <= res_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_index_out = m_index_reg;
    assign m_value_out = m_value_reg;

endmodule
